>>> hdl/tail_drop_packet_buffer_core_defines.svh
// Assertion macros shared by the tail-drop buffer RTL
`ifndef TAIL_DROP_PACKET_BUFFER_CORE_DEFINES_SVH
`define TAIL_DROP_PACKET_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define TDPB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDPB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tdpb_pkg.sv
// Shared widths, defaults and chain control types for the tail-drop buffer
package tdpb_pkg;

  localparam int ARR_W     = 32;
  localparam int PT_W      = 16;
  localparam int TIME_W    = 48;
  localparam int CAP_W     = 7;
  localparam int DEPTH_DEF = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic pop;
    logic push;
  } tdpb_ctrl_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] finish;
  } tdpb_head_t;

endpackage

>>> hdl/tail_drop_packet_buffer_core.sv
// Top level of the tail-drop packet buffer: request control and cell chain
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  in       | start / busy       | in_arrival_time, in_process_time
//  out      | out_valid (strobe) | out_dropped, out_start_time
//  cfg      | cfg_we             | cfg_wdata (capacity)
//
// A request is captured, then retires every expired entry before its decision:
// the head cell is compared against the arrival once per cycle, one pop each.
// The result strobe rises in the cycle after the decision; busy is low then.
// rst_n empties the chain at once (valid bits only), capacity returns to 64.
// The receiver cannot stall; results are never held.
module tail_drop_packet_buffer_core #(
  parameter int DEPTH = tdpb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tdpb_pkg::ARR_W-1:0]  in_arrival_time,
  input  logic [tdpb_pkg::PT_W-1:0]   in_process_time,
  output logic                        out_valid,
  output logic                        out_dropped,
  output logic [tdpb_pkg::TIME_W-1:0] out_start_time,
  input  logic                        cfg_we,
  input  logic [tdpb_pkg::CAP_W-1:0]  cfg_wdata
);
  import tdpb_pkg::*;

  `include "tail_drop_packet_buffer_core_defines.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [ARR_W-1:0]  arr_r;
  logic [PT_W-1:0]   pt_r;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r, out_valid_nxt;
  logic              out_dropped_r, out_dropped_nxt;
  logic [TIME_W-1:0] out_start_r, out_start_nxt;

  tdpb_ctrl_t        ctrl;
  tdpb_head_t        head;
  logic [TIME_W-1:0] arr_ext;
  logic [TIME_W-1:0] start_t;
  logic [TIME_W-1:0] push_finish;
  logic [CMP_W-1:0]  cap_ext;
  logic [CMP_W-1:0]  eff_cap;
  logic              full;
  logic              retire;
  logic              accept;

  assign accept  = start && (state_r == S_IDLE);
  assign arr_ext = TIME_W'(arr_r);
  assign retire  = head.valid && (head.finish <= arr_ext);

  // capacity zero acts as one, anything above the chain length as the length
  assign cap_ext = CMP_W'(cap_r);
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      eff_cap = CMP_W'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign full = CMP_W'(count_r) >= eff_cap;

  assign start_t     = (!head.valid || (arr_ext > last_r)) ? arr_ext : last_r;
  assign push_finish = start_t + TIME_W'(pt_r);

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    last_nxt        = last_r;
    ctrl.pop        = 1'b0;
    ctrl.push       = 1'b0;
    out_valid_nxt   = 1'b0;
    out_dropped_nxt = out_dropped_r;
    out_start_nxt   = out_start_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (retire) begin
          ctrl.pop  = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (head.valid && full) begin
            out_dropped_nxt = 1'b1;
            out_start_nxt   = '0;
          end else begin
            ctrl.push       = 1'b1;
            count_nxt       = count_r + CNT_W'(1);
            last_nxt        = push_finish;
            out_dropped_nxt = 1'b0;
            out_start_nxt   = start_t;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arr_r <= in_arrival_time;
      pt_r  <= in_process_time;
    end
    last_r        <= last_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_start_r   <= out_start_nxt;
  end

  tdpb_chain #(
    .DEPTH (DEPTH)
  ) u_chain (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .push_finish (push_finish),
    .head        (head)
  );

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_dropped    = out_dropped_r;
  assign out_start_time = out_start_r;

  `TDPB_ASSERT_NXT(a_req_busy, accept, busy, "accepted request did not raise busy")
  `TDPB_ASSERT_NXT(a_decide_strobe, (state_r == S_RUN) && !retire, out_valid && !busy, "decision without result strobe")
  `TDPB_ASSERT_IMP(a_pop_push_excl, ctrl.pop, !ctrl.push, "pop and push in one cycle")
  `TDPB_ASSERT_IMP(a_head_count, head.valid, count_r != '0, "head cell valid with zero count")
  `TDPB_ASSERT_NXT(a_push_count, ctrl.push, count_r == $past(count_r) + CNT_W'(1), "push did not bump count")

endmodule

>>> hdl/tdpb_cell.sv
// One slot of the finish-time chain: shifts towards the head on pop, fills on push
module tdpb_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tdpb_pkg::tdpb_ctrl_t       ctrl,
  input  logic                       prev_valid,
  input  logic                       next_valid,
  input  logic [tdpb_pkg::TIME_W-1:0] next_finish,
  input  logic [tdpb_pkg::TIME_W-1:0] push_finish,
  output logic                       valid,
  output logic [tdpb_pkg::TIME_W-1:0] finish
);
  import tdpb_pkg::*;

  logic              valid_r, valid_nxt;
  logic [TIME_W-1:0] finish_r, finish_nxt;

  always_comb begin
    valid_nxt  = valid_r;
    finish_nxt = finish_r;
    if (ctrl.pop) begin
      valid_nxt  = next_valid;
      finish_nxt = next_finish;
    end else if (ctrl.push && !valid_r && prev_valid) begin
      // first empty slot takes the new entry
      valid_nxt  = 1'b1;
      finish_nxt = push_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    finish_r <= finish_nxt;
  end

  assign valid  = valid_r;
  assign finish = finish_r;

endmodule

>>> hdl/tdpb_chain.sv
// Row of finish-time cells; cell 0 is the oldest entry
module tdpb_chain #(
  parameter int DEPTH = tdpb_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tdpb_pkg::tdpb_ctrl_t        ctrl,
  input  logic [tdpb_pkg::TIME_W-1:0] push_finish,
  output tdpb_pkg::tdpb_head_t        head
);
  import tdpb_pkg::*;

  logic              valid_w  [DEPTH];
  logic [TIME_W-1:0] finish_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic              prev_v;
    logic              next_v;
    logic [TIME_W-1:0] next_f;

    if (i == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = valid_w[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign next_v = 1'b0;
      assign next_f = '0;
    end else begin : g_inner
      assign next_v = valid_w[i+1];
      assign next_f = finish_w[i+1];
    end

    tdpb_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .prev_valid  (prev_v),
      .next_valid  (next_v),
      .next_finish (next_f),
      .push_finish (push_finish),
      .valid       (valid_w[i]),
      .finish      (finish_w[i])
    );
  end

  assign head.valid  = valid_w[0];
  assign head.finish = finish_w[0];

endmodule
